FILE: hdl/integer_to_ascii_formatter_core_macros.svh
// Assertion macros shared by the formatter RTL.
`ifndef INTEGER_TO_ASCII_FORMATTER_CORE_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define I2A_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define I2A_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/i2a_pkg.sv
// Types, codes and character helpers of the integer-to-ASCII formatter.
package i2a_pkg;

	// input mode codes
	localparam logic [2:0] MODE_SDEC = 3'd0;
	localparam logic [2:0] MODE_UDEC = 3'd1;
	localparam logic [2:0] MODE_HEXL = 3'd2;
	localparam logic [2:0] MODE_HEXU = 3'd3;
	localparam logic [2:0] MODE_PTR  = 3'd4;

	// ASCII codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LOWA  = 8'h61;
	localparam logic [7:0] CH_UPA   = 8'h41;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_X     = 8'h78;

	localparam int NIBS = 16;

	typedef enum logic [1:0] {
		PFX_NONE,
		PFX_MINUS,
		PFX_HEX
	} pfx_t;

	// one classified item: digit nibbles (LSD in bits 3:0), digit count 1..16
	typedef struct packed {
		logic [63:0] nibs;
		logic [4:0]  ndig;
		pfx_t        pfx;
		logic        upper;
	} rec_t;

	// one digit (0..15) to its ASCII character
	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] r;
		if (d < 4'd10) begin
			r = CH_ZERO + {4'd0, d};
		end else if (upper) begin
			r = CH_UPA + {4'd0, d} - 8'd10;
		end else begin
			r = CH_LOWA + {4'd0, d} - 8'd10;
		end
		return r;
	endfunction

endpackage

FILE: hdl/integer_to_ascii_formatter_core.sv
// Flow: decimal items run through two-bit double dabble in F_CONV before F_PUSH;
// hex and pointer items go straight from F_IDLE to F_PUSH.
// The front takes a new item only in F_IDLE, after the last one has been pushed;
// the back emits one character per cycle while m_tready holds, passing through B_IDLE between items.
// Reset (arst_n low) clears all control state and empties the record queue.
// Top level of the integer-to-ASCII formatter.
module integer_to_ascii_formatter_core #(
	parameter int QDEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // [2:0] mode, [66:3] value, [71:67] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] char_out
	output logic        m_tlast
);
	import i2a_pkg::*;

	logic push;
	logic pop;
	logic q_full;
	logic q_empty;
	rec_t push_rec;
	rec_t pop_rec;

	i2a_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_mode  (s_tdata[2:0]),
		.in_value (s_tdata[66:3]),
		.push     (push),
		.push_rec (push_rec),
		.q_full   (q_full)
	);

	i2a_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (q_full),
		.pop      (pop),
		.pop_rec  (pop_rec),
		.empty    (q_empty)
	);

	i2a_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_rec     (pop_rec),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule

FILE: hdl/i2a_front.sv
// Front end: accepts items, classifies the mode and builds digit records.
module i2a_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [2:0]    in_mode,
	input  logic [63:0]   in_value,
	output logic          push,
	output i2a_pkg::rec_t push_rec,
	input  logic          q_full
);
	import i2a_pkg::*;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CONV,
		F_PUSH
	} fstate_t;

	fstate_t     state_q;
	logic [63:0] nib_q;
	logic [31:0] bin_q;
	logic [3:0]  cnt_q;
	pfx_t        pfx_q;
	logic        upper_q;
	logic [39:0] bcd_next;
	logic [4:0]  ndig;
	logic [31:0] low;
	logic [31:0] mag;

	// one double-dabble step: add 3 to digits >= 5, then shift in one bit
	function automatic logic [39:0] dd_step(input logic [39:0] b, input logic bit_in);
		logic [39:0] t;
		t = b;
		for (int i = 0; i < 10; i++) begin
			if (t[4*i +: 4] >= 4'd5) begin
				t[4*i +: 4] = t[4*i +: 4] + 4'd3;
			end
		end
		return {t[38:0], bit_in};
	endfunction

	// two binary bits per cycle into the BCD register
	assign bcd_next = dd_step(dd_step(nib_q[39:0], bin_q[31]), bin_q[30]);

	// magnitude of the low word
	assign low = in_value[31:0];
	assign mag = (in_mode == MODE_SDEC && low[31]) ? (~low + 32'd1) : low;

	// digit count from the highest nonzero nibble, at least one
	always_comb begin
		ndig = 5'd1;
		for (int i = 0; i < NIBS; i++) begin
			if (nib_q[4*i +: 4] != 4'd0) begin
				ndig = 5'(i + 1);
			end
		end
	end

	assign in_ready = (state_q == F_IDLE);
	assign push     = (state_q == F_PUSH) && !q_full;
	assign push_rec = '{nibs: nib_q, ndig: ndig, pfx: pfx_q, upper: upper_q};

	// control and conversion registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
			nib_q   <= '0;
			bin_q   <= '0;
			pfx_q   <= PFX_NONE;
			upper_q <= 1'b0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						upper_q <= (in_mode == MODE_HEXU);
						bin_q   <= mag;
						cnt_q   <= 4'd15;
						unique case (in_mode)
							MODE_SDEC: begin
								pfx_q   <= low[31] ? PFX_MINUS : PFX_NONE;
								nib_q   <= '0;
								state_q <= F_CONV;
							end
							MODE_UDEC: begin
								pfx_q   <= PFX_NONE;
								nib_q   <= '0;
								state_q <= F_CONV;
							end
							MODE_HEXL, MODE_HEXU: begin
								pfx_q   <= PFX_NONE;
								nib_q   <= in_value;
								state_q <= F_PUSH;
							end
							MODE_PTR: begin
								pfx_q   <= PFX_HEX;
								nib_q   <= in_value;
								state_q <= F_PUSH;
							end
							default: begin
								// unused modes are dropped
								state_q <= F_IDLE;
							end
						endcase
					end
				end
				F_CONV: begin
					nib_q   <= {24'd0, bcd_next};
					bin_q   <= {bin_q[29:0], 2'b00};
					cnt_q   <= cnt_q - 4'd1;
					if (cnt_q == 4'd0) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hdl/i2a_queue.sv
// Short record queue between the front and back ends.
`include "integer_to_ascii_formatter_core_macros.svh"
module i2a_queue #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  i2a_pkg::rec_t push_rec,
	output logic          full,
	input  logic          pop,
	output i2a_pkg::rec_t pop_rec,
	output logic          empty
);
	import i2a_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rec_t          mem_q [DEPTH];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [CW-1:0] cnt_q;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_rec = mem_q[rptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_rec;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	`I2A_ASSERT_IMP(a_no_overflow, clk, arst_n, push, !full, "push into full queue")
	`I2A_ASSERT_IMP(a_no_underflow, clk, arst_n, pop, !empty, "pop from empty queue")

endmodule

FILE: hdl/i2a_back.sv
// Back end: turns digit records into characters and pops the next record only from B_IDLE.
`include "integer_to_ascii_formatter_core_macros.svh"
module i2a_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  i2a_pkg::rec_t q_rec,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_char,
	output logic          out_last
);
	import i2a_pkg::*;

	typedef enum logic [1:0] {
		B_IDLE,
		B_PFX0,
		B_PFX1,
		B_DIG
	} bstate_t;

	bstate_t     state_q;
	logic [63:0] nib_q;
	logic [4:0]  dcnt_q;
	pfx_t        pfx_q;
	logic        upper_q;
	logic        valid_q;
	logic [7:0]  char_q;
	logic        last_q;
	logic        adv;
	logic [3:0]  didx;
	logic [3:0]  dig;

	// output register free or being drained this cycle
	assign adv  = !valid_q || out_ready;
	assign pop  = (state_q == B_IDLE) && !q_empty;
	assign didx = dcnt_q[3:0] - 4'd1;
	assign dig  = nib_q[{didx, 2'b00} +: 4];

	assign out_valid = valid_q;
	assign out_char  = char_q;
	assign out_last  = last_q;

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			valid_q <= 1'b0;
			dcnt_q  <= '0;
			nib_q   <= '0;
			pfx_q   <= PFX_NONE;
			upper_q <= 1'b0;
			char_q  <= '0;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (adv) begin
						valid_q <= 1'b0;
					end
					if (!q_empty) begin
						nib_q   <= q_rec.nibs;
						dcnt_q  <= q_rec.ndig;
						pfx_q   <= q_rec.pfx;
						upper_q <= q_rec.upper;
						state_q <= (q_rec.pfx == PFX_NONE) ? B_DIG : B_PFX0;
					end
				end
				B_PFX0: begin
					if (adv) begin
						valid_q <= 1'b1;
						last_q  <= 1'b0;
						char_q  <= (pfx_q == PFX_MINUS) ? CH_MINUS : CH_ZERO;
						state_q <= (pfx_q == PFX_MINUS) ? B_DIG : B_PFX1;
					end
				end
				B_PFX1: begin
					if (adv) begin
						valid_q <= 1'b1;
						last_q  <= 1'b0;
						char_q  <= CH_X;
						state_q <= B_DIG;
					end
				end
				B_DIG: begin
					if (adv) begin
						valid_q <= 1'b1;
						last_q  <= (dcnt_q == 5'd1);
						char_q  <= digit_char(dig, upper_q);
						dcnt_q  <= dcnt_q - 5'd1;
						if (dcnt_q == 5'd1) begin
							state_q <= B_IDLE;
						end
					end
				end
				default: begin
					if (adv) begin
						valid_q <= 1'b0;
					end
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	`I2A_ASSERT_IMP(a_dig_nonzero, clk, arst_n, state_q == B_DIG, dcnt_q != 5'd0, "empty digit run")
	`I2A_ASSERT_NXT(a_pop_starts, clk, arst_n, pop, state_q != B_IDLE, "pop without run")

endmodule
